[rtl/hufd_pkg.sv]
// shared types and constants for the huffman tree bit decoder
// used by hufd_front, hufd_walk and huffman_tree_bit_decoder
package hufd_pkg;

    localparam int NODE_W      = 9;
    localparam int TREE_NODES  = 2 ** NODE_W;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 8;
    localparam int BIT_CNT_W   = $clog2(CODE_W + 1);
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic              leaf;
        logic [SYM_W-1:0]  sym;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } entry_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [NODE_W-1:0] idx;
        entry_t            ent;
        logic [CODE_W-1:0] code;
    } cmd_t;

endpackage

[rtl/hufd_front.sv]
// input side: accepts stream transactions, classifies them as load or decode
// commands and queues them for the walker; depends on hufd_pkg
module hufd_front
    import hufd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    cmd_t                  queue_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    cmd_t                  in_cmd;
    logic                  push;
    logic                  pop;

    always_comb begin
        in_cmd.kind      = s_tuser ? CMD_DECODE : CMD_LOAD;
        in_cmd.idx       = s_tdata[8:0];
        in_cmd.ent.leaf  = s_tdata[9];
        in_cmd.ent.sym   = s_tdata[17:10];
        in_cmd.ent.left  = s_tdata[26:18];
        in_cmd.ent.right = s_tdata[35:27];
        in_cmd.code      = s_tdata[43:36];
    end

    assign s_tready  = (count_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/hufd_walk.sv]
// back end: node table memory, one tree step per cycle while the output is not stalled, symbol output register
// depends on hufd_pkg
module hufd_walk
    import hufd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } walk_state_t;

    entry_t                 node_mem [TREE_NODES];
    entry_t                 rdata_reg;

    walk_state_t            state_reg, state_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CODE_W-1:0]      bits_reg, bits_next;
    logic [NODE_W-1:0]      walk_reg, walk_next;
    entry_t                 e_reg, e_next;
    entry_t                 root_reg, root_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_direct_reg, pend_direct_next;
    logic [SYM_W-1:0]       pend_sym_reg, pend_sym_next;
    logic [NODE_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [SYM_W-1:0]       hold_sym_reg, hold_sym_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]       m_sym_reg, m_sym_next;
    logic                   m_last_reg, m_last_next;

    logic                   advance;
    logic                   emit;
    logic [SYM_W-1:0]       esym;
    entry_t                 cur_ent;
    logic [NODE_W-1:0]      cur_walk;
    logic                   issue;
    logic                   code_bit;
    logic [NODE_W-1:0]      child;
    logic                   rd_en;
    logic                   mem_we;
    logic                   out_push;
    logic [SYM_W-1:0]       out_sym;
    logic                   out_last;

    assign advance   = !m_valid_reg || m_tready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_sym_reg;
    assign m_tlast   = m_last_reg;

    always_comb begin
        emit     = pend_valid_reg && (pend_direct_reg || rdata_reg.leaf);
        esym     = pend_direct_reg ? pend_sym_reg : rdata_reg.sym;
        if (!pend_valid_reg) begin
            cur_ent  = e_reg;
            cur_walk = walk_reg;
        end else if (emit) begin
            cur_ent  = root_reg;
            cur_walk = '0;
        end else begin
            cur_ent  = rdata_reg;
            cur_walk = pend_addr_reg;
        end
        issue    = (state_reg == ST_RUN) && !cnt_reg[BIT_CNT_W-1];
        code_bit = bits_reg[cnt_reg[BIT_CNT_W-2:0]];
        child    = code_bit ? cur_ent.right : cur_ent.left;
        rd_en    = advance && issue && !cur_ent.leaf;
        mem_we   = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == CMD_LOAD);
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        bits_next        = bits_reg;
        walk_next        = walk_reg;
        e_next           = e_reg;
        root_next        = root_reg;
        pend_valid_next  = pend_valid_reg;
        pend_direct_next = pend_direct_reg;
        pend_sym_next    = pend_sym_reg;
        pend_addr_next   = pend_addr_reg;
        pend_last_next   = pend_last_reg;
        hold_valid_next  = hold_valid_reg;
        hold_sym_next    = hold_sym_reg;
        out_push         = 1'b0;
        out_sym          = hold_sym_reg;
        out_last         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.kind == CMD_LOAD) begin
                        if (cmd.idx == '0) begin
                            root_next = cmd.ent;
                        end
                        if (cmd.idx == walk_reg) begin
                            e_next = cmd.ent;
                        end
                    end else begin
                        bits_next       = cmd.code;
                        cnt_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (advance) begin
                    e_next           = cur_ent;
                    walk_next        = cur_walk;
                    pend_valid_next  = issue;
                    pend_direct_next = cur_ent.leaf;
                    pend_sym_next    = cur_ent.sym;
                    pend_addr_next   = child;
                    pend_last_next   = (cnt_reg[BIT_CNT_W-2:0] == '1);
                    if (issue) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (emit) begin
                        hold_valid_next = 1'b1;
                        hold_sym_next   = esym;
                        if (hold_valid_reg) begin
                            out_push = 1'b1;
                        end
                    end
                    if (pend_valid_reg && pend_last_reg) begin
                        if (emit && hold_valid_reg) begin
                            state_next = ST_FLUSH;
                        end else if (emit) begin
                            out_push        = 1'b1;
                            out_sym         = esym;
                            out_last        = 1'b1;
                            hold_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end else begin
                            out_push        = hold_valid_reg;
                            out_last        = 1'b1;
                            hold_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (advance) begin
                    out_push        = 1'b1;
                    out_last        = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        m_sym_next   = m_sym_reg;
        m_last_next  = m_last_reg;
        if (advance) begin
            m_valid_next = out_push;
            m_sym_next   = out_sym;
            m_last_next  = out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            walk_reg       <= '0;
            pend_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            walk_reg       <= walk_next;
            pend_valid_reg <= pend_valid_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg        <= bits_next;
        e_reg           <= e_next;
        root_reg        <= root_next;
        pend_direct_reg <= pend_direct_next;
        pend_sym_reg    <= pend_sym_next;
        pend_addr_reg   <= pend_addr_next;
        pend_last_reg   <= pend_last_next;
        hold_sym_reg    <= hold_sym_next;
        m_sym_reg       <= m_sym_next;
        m_last_reg      <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[cmd.idx] <= cmd.ent;
        end
        if (rd_en) begin
            rdata_reg <= node_mem[child];
        end
    end

`ifndef SYNTHESIS
    a_pend_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == ST_RUN))
        else $error("pending step outside run");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held symbol left over in idle");

    a_flush_has_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> hold_valid_reg)
        else $error("flush without held symbol");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg <= BIT_CNT_W'(CODE_W)))
        else $error("bit counter out of range");

    a_last_ends_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_push && out_last) |=> (state_reg == ST_IDLE))
        else $error("last symbol sent before byte done");
`endif

endmodule

[rtl/huffman_tree_bit_decoder.sv]
// a decode transaction's symbols pass from the command queue through the walker to the output register;
//   each symbol waits in a hold register until the next symbol or the end of its byte
// the walker takes no new command until it is done with a decode byte, and it makes at most one
//   node table read per code bit
// a load transaction writes the node table from idle; a 4-entry queue sits in front of the walker
// reset: synchronous active-low aresetn clears control and puts the walk at the root;
//   node table contents stay undefined until loaded
module huffman_tree_bit_decoder
    import hufd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // node_index[8:0], node_leaf[9], node_symbol[17:10], left_child[26:18],
    // right_child[35:27], code_byte[43:36], zero[47:44]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // symbol[7:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    hufd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    hufd_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
